// ===== rtl/bfifo_pkg.sv =====
package bfifo_pkg;

   typedef enum logic [1:0] {
      CMD_PUSH      = 2'd0,
      CMD_PUSH_OVER = 2'd1,
      CMD_POP       = 2'd2,
      CMD_PEEK      = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       failed;
      logic [7:0] used_count;
      logic [7:0] free_count;
      logic       is_empty;
      logic       is_full;
   } rsp_type;

   typedef struct packed {
      logic [7:0] used_count;
      logic [7:0] free_count;
      logic       is_empty;
      logic       is_full;
   } count_type;

endpackage

// ===== rtl/bfifo_store.sv =====
module bfifo_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfifo_count.sv =====
module bfifo_count #(
   parameter int IW = 8,
   parameter int LW = 9
) (
   input  logic [LW-1:0]        len,
   input  logic [IW-1:0]        rd_idx,
   input  logic [IW-1:0]        wr_idx,
   output bfifo_pkg::count_type count
);

   localparam int XW = (LW > 8) ? LW : 8;

   logic [LW-1:0] rd_ext;
   logic [LW-1:0] wr_ext;
   logic [LW-1:0] used;
   logic [LW-1:0] free;
   logic [XW-1:0] used_x;
   logic [XW-1:0] free_x;

   always_comb begin
      rd_ext = LW'(rd_idx);
      wr_ext = LW'(wr_idx);
      if (wr_ext >= rd_ext) begin
         used = wr_ext - rd_ext;
      end else begin
         used = len - (rd_ext - wr_ext);
      end
      free   = len - LW'(1) - used;
      used_x = XW'(used);
      free_x = XW'(free);
      count.used_count = used_x[7:0];
      count.free_count = free_x[7:0];
      count.is_empty   = (used == '0);
      count.is_full    = (free == '0);
   end

endmodule

// ===== rtl/byte_ring_fifo.sv =====
// byte fifo on a circular store with push, push-over, pop and peek commands
//
// req channel: one command per transfer (req_valid / req_stall), payload
//   req_data with cmd and data_in. rsp channel: one result per command
//   (rsp_valid / rsp_stall) with the byte read, the fail flag and the
//   used / free counts and empty / full flags after the command.
// csr channel: csr_valid / csr_ready write of the ring length (2..DEPTH,
//   clamped); a write also empties the fifo. write only while idle.
// the command is taken in the idle state; the result is formed in the read
//   state from the registered read of the byte store and presented from the
//   output register. no new command is taken while in the read state.
// a finished result sits in the output register while the next command is
//   taken; if the receiver stalls, the following command is held in the
//   read state and req_stall stays high until the output register drains.
// reset: indices cleared (fifo empty), ring length DEPTH capped at 256, no
//   result pending. store contents are undefined until written.
module byte_ring_fifo #(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bfifo_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bfifo_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [8:0]         csr_data
);

   localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW        = $clog2(DEPTH + 1);
   localparam int CW        = (LW > 9) ? LW : 9;
   localparam int RESET_LEN = (DEPTH < 256) ? DEPTH : 256;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [LW-1:0] len_ff, len_in;
   logic          fail_ff, fail_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bfifo_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          out_free;
   logic [LW-1:0] wr_sum;
   logic [LW-1:0] rd_sum;
   logic [IW-1:0] wr_next;
   logic [IW-1:0] rd_next;
   logic          full;
   logic          empty;
   logic          mem_wr;
   logic [7:0]    mem_rdata;
   logic [CW-1:0] csr_ext;
   logic [CW-1:0] len_clamp;
   bfifo_pkg::count_type count;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ring index advance with wrap at the ring length
   always_comb begin
      wr_sum  = LW'(wr_idx_ff) + LW'(1);
      rd_sum  = LW'(rd_idx_ff) + LW'(1);
      wr_next = (wr_sum >= len_ff) ? '0 : wr_sum[IW-1:0];
      rd_next = (rd_sum >= len_ff) ? '0 : rd_sum[IW-1:0];
      full    = (wr_next == rd_idx_ff);
      empty   = (wr_idx_ff == rd_idx_ff);
   end

   always_comb begin
      csr_ext = CW'(csr_data);
      if (csr_ext < CW'(2)) begin
         len_clamp = CW'(2);
      end else if (csr_ext > CW'(DEPTH)) begin
         len_clamp = CW'(DEPTH);
      end else begin
         len_clamp = csr_ext;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      len_in       = len_ff;
      fail_in      = fail_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_wr       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               len_in    = LW'(len_clamp);
               rd_idx_in = '0;
               wr_idx_in = '0;
            end
            if (accept) begin
               state_in = ST_READ;
               fail_in  = 1'b0;
               rd_ok_in = 1'b0;
               case (req_data.cmd)
                  bfifo_pkg::CMD_PUSH: begin
                     if (full) begin
                        fail_in = 1'b1;
                     end else begin
                        mem_wr    = 1'b1;
                        wr_idx_in = wr_next;
                     end
                  end
                  bfifo_pkg::CMD_PUSH_OVER: begin
                     mem_wr    = 1'b1;
                     wr_idx_in = wr_next;
                     // drop the oldest byte to make room
                     if (full) begin
                        rd_idx_in = rd_next;
                        fail_in   = 1'b1;
                     end
                  end
                  default: begin
                     if (empty) begin
                        fail_in = 1'b1;
                     end else begin
                        rd_ok_in = 1'b1;
                        if (req_data.cmd == bfifo_pkg::CMD_POP) begin
                           rd_idx_in = rd_next;
                        end
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            // counts come from the indices already updated by the command
            if (out_free) begin
               state_in                 = ST_IDLE;
               rsp_valid_in             = 1'b1;
               rsp_data_in.data_out     = rd_ok_ff ? mem_rdata : 8'd0;
               rsp_data_in.failed       = fail_ff;
               rsp_data_in.used_count   = count.used_count;
               rsp_data_in.free_count   = count.free_count;
               rsp_data_in.is_empty     = count.is_empty;
               rsp_data_in.is_full      = count.is_full;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         len_ff       <= LW'(RESET_LEN);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fail_ff     <= fail_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   bfifo_store #(
      .DEPTH (DEPTH),
      .AW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_idx_ff),
      .wr_data (req_data.data_in),
      .rd_en   (accept),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rdata)
   );

   bfifo_count #(
      .IW (IW),
      .LW (LW)
   ) u_count (
      .len    (len_ff),
      .rd_idx (rd_idx_ff),
      .wr_idx (wr_idx_ff),
      .count  (count)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
